@@ hdl/cbsb_pkg.sv @@
// ----------------------------------------------------------------------------
// cbsb_pkg
// Shared constants, register indexes and controller/datapath link types of the
// circular brush smoothing block.
// ----------------------------------------------------------------------------
package cbsb_pkg;

  // default values of the top-level parameters
  localparam int SMOOTH_RADIUS_DEF    = 2;
  localparam int SMOOTH_MAX_DEF       = 100;
  localparam int MAX_BRUSH_RADIUS_DEF = 64;

  // fixed field widths
  localparam int H_W   = 16;
  localparam int MAT_W = 7;
  localparam int CFG_W = 7;
  localparam int IDX_W = 1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_BRUSH_RADIUS    = 1'd0;
  localparam logic [IDX_W-1:0] REG_SMOOTH_STRENGTH = 1'd1;

  // register reset values
  localparam logic [CFG_W-1:0] RADIUS_RESET   = 7'd8;
  localparam logic [CFG_W-1:0] STRENGTH_RESET = 7'd50;

  // read step counter width, covers up to 2*7+1 reads per item
  localparam int K_W = 4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic           in_ready;
    logic           accept;
    logic           rd;
    logic [K_W-1:0] k;
    logic           win;
    logic           mul1;
    logic           mul2;
    logic           mul3;
    logic           div_step;
    logic           load;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_valid;
    logic produce;
    logic blend;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

@@ hdl/cbsb_if.sv @@
// ----------------------------------------------------------------------------
// cbsb_if
// Valid/ready channels for height samples in and smoothed results out.
// ----------------------------------------------------------------------------
interface cbsb_in_if;
  import cbsb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    tile_start;
  logic signed [H_W-1:0]   height;
  logic        [MAT_W-1:0] material;
  logic                    in_map;

  modport source (output valid, tile_start, height, material, in_map, input ready);
  modport sink   (input valid, tile_start, height, material, in_map, output ready);
endinterface

interface cbsb_out_if;
  import cbsb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [H_W-1:0]   height_out;
  logic        [MAT_W-1:0] material_out;
  logic                    smoothed;
  logic                    last;

  modport source (output valid, height_out, material_out, smoothed, last, input ready);
  modport sink   (input valid, height_out, material_out, smoothed, last, output ready);
endinterface

@@ hdl/cbsb_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbsb_ctrl
// Sequencer: line store reads, window update, blend products, divider steps
// and result hand-off for one item at a time.
// ----------------------------------------------------------------------------
module cbsb_ctrl
  import cbsb_pkg::*;
#(
  parameter int SMOOTH_RADIUS = SMOOTH_RADIUS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam int LINES = 2 * SMOOTH_RADIUS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_ACC, ST_WIN, ST_MUL1, ST_MUL2, ST_MUL3, ST_DIV, ST_OUT
  } state_e;

  state_e         state_q, state_d;
  logic [K_W-1:0] k_q, k_d;

  // next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid) begin
          state_d = ST_RD;
          k_d     = K_W'(1);
        end
      end
      ST_RD: begin
        if (k_q == K_W'(LINES + 1)) state_d = ST_ACC;
        else k_d = k_q + K_W'(1);
      end
      ST_ACC:  state_d = ST_WIN;
      ST_WIN:  state_d = status_i.produce ? ST_MUL1 : ST_IDLE;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = status_i.blend ? ST_DIV : ST_OUT;
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.in_ready = (state_q == ST_IDLE);
    cmd_o.accept   = (state_q == ST_IDLE) && status_i.in_valid;
    cmd_o.rd       = (state_q == ST_RD);
    cmd_o.k        = k_q;
    cmd_o.win      = (state_q == ST_WIN);
    cmd_o.mul1     = (state_q == ST_MUL1);
    cmd_o.mul2     = (state_q == ST_MUL2);
    cmd_o.mul3     = (state_q == ST_MUL3);
    cmd_o.div_step = (state_q == ST_DIV) && !status_i.div_done;
    cmd_o.load     = (state_q == ST_OUT) && status_i.out_free;
  end

endmodule

@@ hdl/cbsb_dpath.sv @@
// ----------------------------------------------------------------------------
// cbsb_dpath
// Line store, position counters, column sums, running window total, blend
// products, bit-serial divider and output register.
// ----------------------------------------------------------------------------
module cbsb_dpath
  import cbsb_pkg::*;
#(
  parameter int SMOOTH_RADIUS    = SMOOTH_RADIUS_DEF,
  parameter int SMOOTH_MAX       = SMOOTH_MAX_DEF,
  parameter int MAX_BRUSH_RADIUS = MAX_BRUSH_RADIUS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  cbsb_in_if.sink          sample_i,
  cbsb_out_if.source       result_o
);

  localparam int WIN     = 2 * SMOOTH_RADIUS + 1;
  localparam int LINES   = 2 * SMOOTH_RADIUS;
  localparam int ROW_LEN = 2 * MAX_BRUSH_RADIUS + 2 * SMOOTH_RADIUS;
  localparam int DEPTH   = LINES * ROW_LEN;
  localparam int AW      = $clog2(DEPTH);
  localparam int XW      = $clog2(ROW_LEN + 1);
  localparam int SL_W    = $clog2(LINES);
  localparam int ST_W    = $clog2(2 * LINES + 1);
  localparam int R_W     = $clog2(MAX_BRUSH_RADIUS + 1);
  localparam int RC_W    = (R_W > CFG_W) ? R_W : CFG_W;
  localparam int S_W     = $clog2(SMOOTH_MAX + 1);
  localparam int SC_W    = (S_W > CFG_W) ? S_W : CFG_W;
  localparam int CCNT_W  = $clog2(WIN + 1);
  localparam int CNT_W   = $clog2(WIN * WIN + 1);
  localparam int CS_W    = H_W + $clog2(WIN) + 1;
  localparam int WS_W    = H_W + $clog2(WIN * WIN) + 1;
  localparam int P1_W    = WS_W + S_W + 1;
  localparam int P2_W    = H_W + CNT_W + 1;
  localparam int P3_W    = P2_W + S_W + 1;
  localparam int NUM_W   = ((P1_W > P3_W) ? P1_W : P3_W) + 1;
  localparam int DEN_W   = CNT_W + S_W;
  localparam int DC_W    = $clog2(NUM_W + 1);
  localparam int D_W     = XW + 2;
  localparam int SQ_W    = 2 * D_W + 1;
  localparam int E_W     = 1 + MAT_W + H_W;

  // configuration registers
  logic [CFG_W-1:0] radius_cfg_q, strength_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_cfg_q   <= RADIUS_RESET;
      strength_cfg_q <= STRENGTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BRUSH_RADIUS:    radius_cfg_q   <= cfg_data_i;
        REG_SMOOTH_STRENGTH: strength_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped radius, strength and tile width
  logic [RC_W-1:0] r_ext;
  logic [SC_W-1:0] s_ext;
  logic [R_W-1:0]  r_c;
  logic [S_W-1:0]  s_c;
  logic [XW-1:0]   w_c;

  always_comb begin
    r_ext = RC_W'(radius_cfg_q);
    s_ext = SC_W'(strength_cfg_q);
    if (r_ext == '0) r_c = R_W'(1);
    else if (r_ext > RC_W'(MAX_BRUSH_RADIUS)) r_c = R_W'(MAX_BRUSH_RADIUS);
    else r_c = R_W'(r_ext);
    if (s_ext > SC_W'(SMOOTH_MAX)) s_c = S_W'(SMOOTH_MAX);
    else s_c = S_W'(s_ext);
    w_c = XW'(r_c) + XW'(r_c) + XW'(2 * SMOOTH_RADIUS);
  end

  // position state and per-item latches
  logic [XW-1:0]          posx_q, posz_q, curx_q, curz_q, w_q;
  logic [SL_W-1:0]        poss_q, curs_q;
  logic [R_W-1:0]         r_q;
  logic [2*R_W-1:0]       r2_q;
  logic [S_W-1:0]         s_q, ms_q;
  logic signed [H_W-1:0]  h_q;
  logic [MAT_W-1:0]       mat_q;
  logic                   inm_q;
  logic                   produce_q, last_q;
  logic                   restart;

  assign restart = sample_i.tile_start || (posx_q >= w_c) || (posz_q >= w_c);

  // line store read and write addressing
  function automatic logic [SL_W-1:0] slot_back(input logic [SL_W-1:0] base,
                                                input logic [K_W-1:0]  off);
    logic [ST_W-1:0] t;
    t = ST_W'(base) + ST_W'(LINES) - ST_W'(off);
    if (t >= ST_W'(LINES)) t = t - ST_W'(LINES);
    return t[SL_W-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [SL_W-1:0] sl,
                                            input logic [XW-1:0]   col);
    return AW'(sl) * AW'(ROW_LEN) + AW'(col);
  endfunction

  logic [AW-1:0] rd_addr, wr_addr;

  always_comb begin
    if (cmd_i.k <= K_W'(LINES)) begin
      rd_addr = addr_of(slot_back(curs_q, cmd_i.k), curx_q);
    end else begin
      rd_addr = addr_of(slot_back(curs_q, K_W'(SMOOTH_RADIUS)),
                        curx_q - XW'(SMOOTH_RADIUS));
    end
    wr_addr = addr_of(curs_q, curx_q);
  end

  // line store
  logic [E_W-1:0] mem [DEPTH];
  logic [E_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rdata_q <= mem[rd_addr];
    if (cmd_i.win) mem[wr_addr] <= {inm_q, mat_q, h_q};
  end

  // read tracking
  logic           rpend_q;
  logic [K_W-1:0] rk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpend_q <= 1'b0;
      rk_q    <= '0;
    end else begin
      rpend_q <= cmd_i.rd;
      rk_q    <= cmd_i.k;
    end
  end

  logic signed [H_W-1:0] rd_h;
  assign rd_h = $signed(rdata_q[H_W-1:0]);

  // column sum of the current column and the source sample
  logic signed [CS_W-1:0] csum_q;
  logic [CCNT_W-1:0]      ccnt_q;
  logic signed [H_W-1:0]  src_h_q;
  logic [MAT_W-1:0]       src_mat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      csum_q <= sample_i.in_map ? CS_W'(sample_i.height) : '0;
      ccnt_q <= CCNT_W'(sample_i.in_map);
    end else if (rpend_q) begin
      if (rk_q <= K_W'(LINES)) begin
        if (curz_q >= XW'(rk_q) && rdata_q[E_W-1]) begin
          csum_q <= csum_q + CS_W'(rd_h);
          ccnt_q <= ccnt_q + CCNT_W'(1);
        end
      end else begin
        src_h_q   <= rd_h;
        src_mat_q <= rdata_q[H_W +: MAT_W];
      end
    end
  end

  // item latch and position counters
  logic [XW-1:0]   nx, nz;
  logic [SL_W-1:0] ns;

  always_comb begin
    nx = curx_q + XW'(1);
    nz = curz_q;
    ns = curs_q;
    if (nx >= w_q) begin
      nx = '0;
      nz = curz_q + XW'(1);
      ns = (curs_q == SL_W'(LINES - 1)) ? '0 : curs_q + SL_W'(1);
      if (nz >= w_q) begin
        nz = '0;
        ns = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posx_q <= '0;
      posz_q <= '0;
      poss_q <= '0;
    end else if (cmd_i.win) begin
      posx_q <= nx;
      posz_q <= nz;
      poss_q <= ns;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      curx_q    <= restart ? '0 : posx_q;
      curz_q    <= restart ? '0 : posz_q;
      curs_q    <= restart ? '0 : poss_q;
      produce_q <= !restart && (posx_q >= XW'(LINES)) && (posz_q >= XW'(LINES));
      w_q       <= w_c;
      r_q       <= r_c;
      r2_q      <= (2*R_W)'(r_c) * (2*R_W)'(r_c);
      s_q       <= s_c;
      ms_q      <= S_W'(SMOOTH_MAX) - s_c;
      h_q       <= sample_i.height;
      mat_q     <= sample_i.material;
      inm_q     <= sample_i.in_map;
    end
  end

  // column shift line and running window total
  logic signed [CS_W-1:0] colsum_q [WIN];
  logic [CCNT_W-1:0]      colcnt_q [WIN];
  logic signed [WS_W-1:0] winsum_q;
  logic [CNT_W-1:0]       wincnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN; i++) begin
        colsum_q[i] <= '0;
        colcnt_q[i] <= '0;
      end
      winsum_q <= '0;
      wincnt_q <= '0;
    end else if (cmd_i.win) begin
      for (int i = 0; i < WIN - 1; i++) begin
        colsum_q[i] <= colsum_q[i+1];
        colcnt_q[i] <= colcnt_q[i+1];
      end
      colsum_q[WIN-1] <= csum_q;
      colcnt_q[WIN-1] <= ccnt_q;
      winsum_q <= winsum_q + WS_W'(csum_q) - WS_W'(colsum_q[0]);
      wincnt_q <= wincnt_q + CNT_W'(ccnt_q) - CNT_W'(colcnt_q[0]);
    end
  end

  // circle distance squares
  logic signed [D_W-1:0]   dx, dz;
  logic signed [2*D_W-1:0] dx2_q, dz2_q;

  assign dx = $signed({2'b00, curx_q}) - D_W'(2 * SMOOTH_RADIUS) - $signed(D_W'(r_q));
  assign dz = $signed({2'b00, curz_q}) - D_W'(2 * SMOOTH_RADIUS) - $signed(D_W'(r_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.win) begin
      dx2_q  <= dx * dx;
      dz2_q  <= dz * dz;
      last_q <= (curx_q == w_q - XW'(1)) && (curz_q == w_q - XW'(1));
    end
  end

  // blend products
  logic signed [P1_W-1:0]  p1_q;
  logic signed [P2_W-1:0]  p2_q;
  logic signed [P3_W-1:0]  p3_q;
  logic [DEN_W-1:0]        den_q;
  logic                    blend_q;
  logic signed [NUM_W-1:0] num;

  assign num = NUM_W'(p1_q) + NUM_W'(p3_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p1_q    <= P1_W'(winsum_q) * P1_W'($signed({1'b0, s_q}));
      p2_q    <= P2_W'(src_h_q) * P2_W'($signed({1'b0, wincnt_q}));
      den_q   <= DEN_W'(wincnt_q) * DEN_W'(SMOOTH_MAX);
      blend_q <= (SQ_W'(dx2_q) + SQ_W'(dz2_q) <= SQ_W'(r2_q)) && (wincnt_q != '0);
    end
    if (cmd_i.mul2) begin
      p3_q <= P3_W'(p2_q) * P3_W'($signed({1'b0, ms_q}));
    end
  end

  // restoring divider, one quotient bit per step
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DC_W-1:0]  dcnt_q;
  logic             neg_q;
  logic [DEN_W:0]   rem_sh;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.mul3) begin
      dcnt_q <= DC_W'(NUM_W);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - DC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul3) begin
      neg_q <= num[NUM_W-1];
      quo_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  // output register
  logic                  out_valid_q;
  logic signed [H_W-1:0] out_h_q;
  logic [MAT_W-1:0]      out_mat_q;
  logic                  out_sm_q, out_last_q;
  logic [H_W-1:0]        q_lo;

  assign q_lo = quo_q[H_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_h_q    <= blend_q ? $signed(neg_q ? -q_lo : q_lo) : src_h_q;
      out_mat_q  <= src_mat_q;
      out_sm_q   <= blend_q;
      out_last_q <= last_q;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.height_out   = out_h_q;
  assign result_o.material_out = out_mat_q;
  assign result_o.smoothed     = out_sm_q;
  assign result_o.last         = out_last_q;
  assign sample_i.ready        = cmd_i.in_ready;

  // status
  assign status_o.in_valid = sample_i.valid;
  assign status_o.produce  = produce_q;
  assign status_o.blend    = blend_q;
  assign status_o.div_done = (dcnt_q == '0);
  assign status_o.out_free = !out_valid_q || result_o.ready;

endmodule

@@ hdl/circular_box_smooth_blend.sv @@
// ----------------------------------------------------------------------------
// circular_box_smooth_blend
// Box-averaged height smoothing blended through a circular brush mask.
// ----------------------------------------------------------------------------
// one item at a time: line store reads, window update, then for an item with
// a result the blend products, the divider steps when blended and the output
// register; one line store read per cycle and a one-bit-per-cycle divider
// (NUM_W = 31); a held result stalls only the next item with a result
// asynchronous active-low reset clears counters, window sums and result valid
// and loads the reset values of the configuration registers
module circular_box_smooth_blend
  import cbsb_pkg::*;
#(
  parameter int SMOOTH_RADIUS    = SMOOTH_RADIUS_DEF,
  parameter int SMOOTH_MAX       = SMOOTH_MAX_DEF,
  parameter int MAX_BRUSH_RADIUS = MAX_BRUSH_RADIUS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  cbsb_in_if.sink          sample_i,
  cbsb_out_if.source       result_o
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  cbsb_ctrl #(
    .SMOOTH_RADIUS(SMOOTH_RADIUS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .cmd_o   (cmd)
  );

  // datapath
  cbsb_dpath #(
    .SMOOTH_RADIUS   (SMOOTH_RADIUS),
    .SMOOTH_MAX      (SMOOTH_MAX),
    .MAX_BRUSH_RADIUS(MAX_BRUSH_RADIUS)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .sample_i  (sample_i),
    .result_o  (result_o)
  );

endmodule

@@ verif/circular_box_smooth_blend_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_box_smooth_blend_tb
// Self-checking bench for the circular brush smoothing block: height tiles
// are streamed in with random gaps and stalls, and every result is compared
// field by field with a cycle-free predictor that runs inside the bench.
// ----------------------------------------------------------------------------
module circular_box_smooth_blend_tb;
  import cbsb_pkg::*;

  localparam int SR       = SMOOTH_RADIUS_DEF;
  localparam int SMAX     = SMOOTH_MAX_DEF;
  localparam int RMAX     = MAX_BRUSH_RADIUS_DEF;
  localparam int WIN      = 2 * SR + 1;
  localparam int LINES    = 2 * SR;
  localparam int ROW_LEN  = 2 * RMAX + 2 * SR;
  localparam int SETTLE   = 40;
  localparam int LIMIT    = 3000000;
  localparam int N_ITEMS  = 1650;

  typedef struct packed {
    logic signed [H_W-1:0]   height;
    logic        [MAT_W-1:0] material;
    logic                    smoothed;
    logic                    last;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic             cfg_we_i   = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i  = REG_BRUSH_RADIUS;
  logic [CFG_W-1:0] cfg_data_i = '0;

  cbsb_in_if  sample_if ();
  cbsb_out_if result_if ();

  circular_box_smooth_blend u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .sample_i  (sample_if),
    .result_o  (result_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [CFG_W-1:0]       radius_reg   = RADIUS_RESET;
  logic [CFG_W-1:0]       strength_reg = STRENGTH_RESET;
  int                     line_h [LINES*ROW_LEN];
  logic [MAT_W-1:0]       line_mat [LINES*ROW_LEN];
  bit                     line_inmap [LINES*ROW_LEN];
  int                     col_sum [WIN];
  int                     col_cnt [WIN];
  int                     x_pos, z_pos;
  result_t                pending_results [$];

  int  n_sent, n_checked, n_blended, n_errors, cycles;
  bit  no_idle;

  function automatic int slot(int row, int col);
    return (row % LINES) * ROW_LEN + (col % ROW_LEN);
  endfunction

  // compute the result caused by one accepted sample
  function automatic void smooth_sample(bit ts, logic signed [H_W-1:0] h,
                                        logic [MAT_W-1:0] mat, bit inm);
    int r, s, w, csum, ccnt, px, pz, dx, dz, src;
    longint sum, cnt, num, den;
    result_t res;
    r = radius_reg;
    s = strength_reg;
    if (r < 1) r = 1;
    if (r > RMAX) r = RMAX;
    if (s > SMAX) s = SMAX;
    w = 2 * r + 2 * SR;
    if (ts) begin
      x_pos = 0;
      z_pos = 0;
    end
    if (x_pos >= w || z_pos >= w) begin
      x_pos = 0;
      z_pos = 0;
    end
    // vertical column sum through the line store
    csum = inm ? int'(h) : 0;
    ccnt = inm;
    for (int k = 1; k <= LINES; k++) begin
      if (z_pos >= k && line_inmap[slot(z_pos - k, x_pos)]) begin
        csum += line_h[slot(z_pos - k, x_pos)];
        ccnt++;
      end
    end
    for (int i = 0; i < WIN - 1; i++) begin
      col_sum[i] = col_sum[i+1];
      col_cnt[i] = col_cnt[i+1];
    end
    col_sum[WIN-1] = csum;
    col_cnt[WIN-1] = ccnt;
    // a full window has arrived for the position two rows and columns back
    if (x_pos >= LINES && z_pos >= LINES) begin
      px  = x_pos - SR;
      pz  = z_pos - SR;
      src = slot(pz, px);
      dx  = px - SR - r;
      dz  = pz - SR - r;
      sum = 0;
      cnt = 0;
      for (int i = 0; i < WIN; i++) begin
        sum += col_sum[i];
        cnt += col_cnt[i];
      end
      res.height   = line_h[src];
      res.material = line_mat[src];
      res.smoothed = 1'b0;
      if (dx * dx + dz * dz <= r * r && cnt > 0) begin
        num = sum * s + longint'(line_h[src]) * cnt * (SMAX - s);
        den = cnt * SMAX;
        res.height   = H_W'(num / den);
        res.smoothed = 1'b1;
      end
      res.last = (x_pos == w - 1 && z_pos == w - 1);
      pending_results.push_back(res);
    end
    line_h[slot(z_pos, x_pos)]     = h;
    line_mat[slot(z_pos, x_pos)]   = mat;
    line_inmap[slot(z_pos, x_pos)] = inm;
    x_pos++;
    if (x_pos >= w) begin
      x_pos = 0;
      z_pos++;
      if (z_pos >= w) z_pos = 0;
    end
  endfunction

  function automatic int rand_gap();
    int p;
    p = $urandom_range(99);
    if (no_idle || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int brush_width();
    int r;
    r = radius_reg;
    if (r < 1) r = 1;
    if (r > RMAX) r = RMAX;
    return 2 * r + 2 * SR;
  endfunction

  // send one sample; valid stays high when no gap follows
  task automatic send_sample(bit ts, logic signed [H_W-1:0] h, logic [MAT_W-1:0] mat,
                             bit inm);
    int gap;
    sample_if.valid      <= 1'b1;
    sample_if.tile_start <= ts;
    sample_if.height     <= h;
    sample_if.material   <= mat;
    sample_if.in_map     <= inm;
    do @(posedge clk_i); while (!sample_if.ready);
    smooth_sample(ts, h, mat, inm);
    n_sent++;
    gap = rand_gap();
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until every expected result is in, then let the block settle
  task automatic drain();
    sample_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_BRUSH_RADIUS) radius_reg = val;
    else strength_reg = val;
  endtask

  function automatic logic signed [H_W-1:0] rand_height();
    case ($urandom_range(3))
      0: return H_W'($urandom);
      1: return H_W'($urandom_range(0, 400)) - 16'sd200;
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return H_W'($urandom_range(0, 8000)) - 16'sd4000;
    endcase
  endfunction

  // one tile of n samples; inm_mode 0 all in map, 1 sparse holes, 2 none
  task automatic send_tile(int n, bit ts_first, int inm_mode);
    bit inm;
    for (int i = 0; i < n; i++) begin
      case (inm_mode)
        0: inm = 1'b1;
        1: inm = $urandom_range(9) != 0;
        default: inm = 1'b0;
      endcase
      send_sample(ts_first && i == 0, rand_height(), MAT_W'($urandom), inm);
    end
  endtask

  // register clamping, with extreme heights over a radius-one brush
  task automatic test_clamped_registers();
    write_reg(REG_BRUSH_RADIUS, 7'd0);
    write_reg(REG_SMOOTH_STRENGTH, 7'd127);
    for (int i = 0; i < brush_width() ** 2; i++)
      send_sample(i == 0, (i % 3 == 0) ? 16'sh7fff : (i % 3 == 1) ? 16'sh8000 : 16'sd0,
                  (i % 2) ? 7'h7f : 7'h00, i != 14);
  endtask

  // no sample in map: every position passes through
  task automatic test_empty_window();
    write_reg(REG_SMOOTH_STRENGTH, 7'd0);
    send_tile(brush_width() ** 2, 1'b1, 2);
  endtask

  // full strength, two tiles back to back with no tile start on the second
  task automatic test_tile_wrap();
    write_reg(REG_SMOOTH_STRENGTH, 7'd100);
    write_reg(REG_BRUSH_RADIUS, 7'd2);
    no_idle = 1'b1;
    send_tile(brush_width() ** 2, 1'b1, 0);
    no_idle = 1'b0;
    send_tile(brush_width() ** 2, 1'b0, 1);
  endtask

  // radius shrinks while the counters sit beyond the new tile
  task automatic test_radius_shrink();
    write_reg(REG_BRUSH_RADIUS, 7'd3);
    send_tile(brush_width() * 7, 1'b1, 1);
    write_reg(REG_BRUSH_RADIUS, 7'd1);
    send_tile(brush_width() ** 2, 1'b0, 0);
  endtask

  // oversized radius clamps to the largest brush; partial tile only
  task automatic test_largest_brush();
    write_reg(REG_BRUSH_RADIUS, 7'd127);
    write_reg(REG_SMOOTH_STRENGTH, 7'd63);
    send_tile(brush_width() * (LINES + 1), 1'b1, 1);
  endtask

  // random tiles, mostly whole, some cut short or restarted part way
  task automatic test_random_tiles();
    int n;
    bit restart;
    while (n_sent < N_ITEMS) begin
      restart = (x_pos != 0 || z_pos != 0);
      if ($urandom_range(2) == 0) begin
        write_reg(REG_BRUSH_RADIUS, ($urandom_range(7) == 0) ? CFG_W'($urandom_range(0, 7))
                                                         : CFG_W'($urandom_range(1, 4)));
        restart = 1'b1;
      end
      if ($urandom_range(2) == 0)
        write_reg(REG_SMOOTH_STRENGTH, ($urandom_range(4) == 0) ? CFG_W'($urandom)
                                                             : CFG_W'($urandom_range(100)));
      no_idle = ($urandom_range(4) == 0);
      n = brush_width() ** 2;
      if ($urandom_range(9) == 0) n = $urandom_range(1, n);
      send_tile(n, restart || $urandom_range(5) == 0,
                ($urandom_range(9) == 0) ? 2 : $urandom_range(1));
    end
    no_idle = 1'b0;
  endtask

  // result side: random stalls, compare with the oldest expectation
  int stall_left;
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item h=%0d mat=%0d sm=%0b last=%0b", $time,
                 result_if.height_out, result_if.material_out, result_if.smoothed,
                 result_if.last);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.smoothed) n_blended++;
        if (result_if.height_out !== want.height) begin
          $display("%0t: height_out expected %0d got %0d", $time, want.height,
                   result_if.height_out);
          n_errors++;
        end
        if (result_if.material_out !== want.material) begin
          $display("%0t: material_out expected %0d got %0d", $time, want.material,
                   result_if.material_out);
          n_errors++;
        end
        if (result_if.smoothed !== want.smoothed) begin
          $display("%0t: smoothed expected %0b got %0b", $time, want.smoothed,
                   result_if.smoothed);
          n_errors++;
        end
        if (result_if.last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, result_if.last);
          n_errors++;
        end
      end
    end
    if (no_idle) begin
      result_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else begin
      stall_left = rand_gap();
      result_if.ready <= (stall_left == 0);
    end
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    sample_if.valid      = 1'b0;
    sample_if.tile_start = 1'b0;
    sample_if.height     = '0;
    sample_if.material   = '0;
    sample_if.in_map     = 1'b0;
    result_if.ready      = 1'b0;
    for (int i = 0; i < LINES * ROW_LEN; i++) begin
      line_h[i]     = 0;
      line_mat[i]   = '0;
      line_inmap[i] = 1'b0;
    end
    for (int i = 0; i < WIN; i++) begin
      col_sum[i] = 0;
      col_cnt[i] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_clamped_registers();
    test_empty_window();
    test_tile_wrap();
    test_radius_shrink();
    test_largest_brush();
    test_random_tiles();

    drain();
    if (pending_results.size() != 0) n_errors++;
    $display("run covered %0d samples over brush radii 1 to %0d, clamped registers,",
             n_sent, RMAX);
    $display("%0d results checked, %0d of them blended, %0d mismatches", n_checked,
             n_blended, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
